[design/nau_pkg.sv]
// Package for the accumulator update block: op codes, sizes and feature helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nau_pkg;
	localparam int HiddenSizeDefault = 256;
	localparam int LanesDefault      = 8;
	localparam int NumFeatures       = 768;
	localparam int FeatW             = 10;

	typedef enum logic [2:0] {
		OP_WR_WEIGHT = 3'd0,
		OP_WR_BIAS   = 3'd1,
		OP_RST_ACC   = 3'd2,
		OP_ADD_PIECE = 3'd3,
		OP_MOVE      = 3'd4,
		OP_READ      = 3'd5
	} op_t;

	localparam logic [2:0] CastleWq = 3'd1;
	localparam logic [2:0] CastleWk = 3'd2;
	localparam logic [2:0] CastleBq = 3'd3;
	localparam logic [2:0] CastleBk = 3'd4;
	localparam logic [1:0] CapNormal = 2'd1;
	localparam logic [1:0] CapEp     = 2'd2;
	localparam logic [2:0] PieceRook = 3'd3;
	localparam logic [2:0] PiecePawn = 3'd0;

	// Feature slot: valid flag and feature index (bit 10 set only by the bias marker)
	typedef struct packed {
		logic        vld;
		logic [10:0] feat;
	} slot_t;

	// Row-update command from controller to datapath
	typedef struct packed {
		logic        run;     // start a row sweep
		logic        bias;    // load accumulators from bias row
		logic        persp;
		logic        sub;
		logic [FeatW-1:0] feat;
	} cmd_t;

	function automatic logic [10:0] feature_of(input logic [5:0] sq, input logic color,
			input logic [2:0] piece);
		logic [5:0] s;
		begin
			s = color ? (sq ^ 6'd56) : sq;
			feature_of = {piece, s, color};
		end
	endfunction
endpackage
`default_nettype wire

[design/nau_datapath.sv]
// Datapath: weight, bias and accumulator memories and the lane sweep engine.
// Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nau_datapath #(
	parameter int HIDDEN_SIZE     = nau_pkg::HiddenSizeDefault,
	parameter int LANES_PER_CYCLE = nau_pkg::LanesDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire nau_pkg::cmd_t  cmd,
	input  wire logic           wr_weight,
	input  wire logic           wr_bias,
	input  wire logic           rd_acc,
	input  wire logic [17:0]    index,
	input  wire logic signed [15:0] value,
	output logic                done,
	output logic signed [31:0]  read_value
);
	localparam int LaneW   = $clog2(HIDDEN_SIZE);
	localparam int Groups  = HIDDEN_SIZE / LANES_PER_CYCLE;
	localparam int GrpW    = (Groups > 1) ? $clog2(Groups) : 1;
	localparam int SubW    = (LANES_PER_CYCLE > 1) ? $clog2(LANES_PER_CYCLE) : 1;
	localparam int WDepth  = nau_pkg::NumFeatures * Groups;
	localparam int WAddrW  = $clog2(WDepth);
	localparam int AAddrW  = GrpW + 1;

	typedef logic signed [LANES_PER_CYCLE*16-1:0] wrow_t;
	typedef logic signed [LANES_PER_CYCLE*32-1:0] arow_t;
	typedef logic [LANES_PER_CYCLE-1:0] lmask_t;

	// Memories, one row holds a group of lanes
	wrow_t wmem_q [WDepth];
	wrow_t bmem_q [Groups];
	arow_t amem_q [2*Groups];
	// Per-row valid bits for accumulators (reset value zero)
	logic [2*Groups-1:0] aval_q;

	// Sweep control
	logic           busy_q;
	logic [GrpW-1:0] grp_q;
	logic           bias_q, persp_q, sub_q;
	logic [nau_pkg::FeatW-1:0] feat_q;
	// Stage 1: registered reads
	logic           vld_s1;
	logic [AAddrW-1:0] aaddr_s1;
	logic           sub_s1, bias_s1, last_s1;
	wrow_t          w_s1;
	arow_t          a_s1;
	logic           aval_s1;

	// Address split for single-word writes
	logic [LaneW-1:0] wlane;
	logic [GrpW-1:0]  wgrp;
	logic [SubW-1:0]  wsub;
	logic [WAddrW-1:0] waddr;
	logic [17:0] wfeat;
	assign wlane = index[LaneW-1:0];
	assign wfeat = index >> LaneW;
	assign wgrp  = GrpW'(wlane / LANES_PER_CYCLE);
	assign wsub  = SubW'(wlane % LANES_PER_CYCLE);
	assign waddr = WAddrW'(wfeat * Groups) + WAddrW'(wgrp);

	logic [WAddrW-1:0] raddr;
	logic [AAddrW-1:0] caddr;
	assign raddr = WAddrW'(feat_q * Groups) + WAddrW'(grp_q);
	assign caddr = {persp_q, grp_q};

	// Write single words into their lane of the row
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES_PER_CYCLE; i++) begin
			if (wsub == SubW'(i)) begin
				if (wr_weight && (wfeat < 18'(nau_pkg::NumFeatures)))
					wmem_q[waddr][i*16 +: 16] <= value;
				if (wr_bias && (index < 18'(HIDDEN_SIZE)))
					bmem_q[wgrp][i*16 +: 16] <= value;
			end
		end
	end

	// Advance the sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
			if (cmd.run) begin
				busy_q <= 1'b1;
				grp_q  <= '0;
			end else if (busy_q) begin
				grp_q <= grp_q + 1'b1;
				if (grp_q == GrpW'(Groups-1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run) begin
			bias_q  <= cmd.bias;
			persp_q <= cmd.persp;
			sub_q   <= cmd.sub;
			feat_q  <= cmd.feat;
		end
		aaddr_s1 <= caddr;
		sub_s1   <= sub_q;
		bias_s1  <= bias_q;
		last_s1  <= (grp_q == GrpW'(Groups-1));
		w_s1     <= bias_q ? bmem_q[grp_q] : wmem_q[raddr];
		a_s1     <= amem_q[caddr];
		aval_s1  <= aval_q[caddr];
	end

	// Saturating add or subtract per lane, or bias load, write back
	arow_t nrow;
	always_comb begin
		for (int i = 0; i < LANES_PER_CYCLE; i++) begin
			logic signed [33:0] s;
			logic signed [31:0] a;
			logic signed [16:0] w;
			a = aval_s1 ? a_s1[i*32 +: 32] : 32'sd0;
			w = sub_s1 ? -17'(signed'(w_s1[i*16 +: 16])) : 17'(signed'(w_s1[i*16 +: 16]));
			s = 34'(a) + 34'(w);
			if (bias_s1) nrow[i*32 +: 32] = 32'(signed'(w_s1[i*16 +: 16]));
			else if (s > 34'sh7FFFFFFF) nrow[i*32 +: 32] = 32'h7FFFFFFF;
			else if (s < -34'sh80000000) nrow[i*32 +: 32] = 32'h80000000;
			else nrow[i*32 +: 32] = s[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) amem_q[aaddr_s1] <= nrow;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) aval_q <= '0;
		else if (vld_s1) aval_q[aaddr_s1] <= 1'b1;
	end
	assign done = vld_s1 && last_s1;

	// Read one lane: registered row, then combinational lane select
	logic [AAddrW-1:0] rrow;
	logic [SubW-1:0] rsub;
	logic rin;
	arow_t rrow_q;
	logic  rval_q, rin_q;
	logic [SubW-1:0] rsub_q;
	assign rin  = index < 18'(2*HIDDEN_SIZE);
	assign rrow = AAddrW'(index[LaneW:0] / LANES_PER_CYCLE);
	assign rsub = SubW'(index[LaneW:0] % LANES_PER_CYCLE);
	always_ff @(posedge clk) begin
		if (rd_acc) begin
			rrow_q <= amem_q[rrow];
			rval_q <= aval_q[rrow];
			rin_q  <= rin;
			rsub_q <= rsub;
		end
	end
	always_comb begin
		read_value = '0;
		for (int i = 0; i < LANES_PER_CYCLE; i++)
			if (rsub_q == SubW'(i) && rval_q && rin_q)
				read_value = rrow_q[i*32 +: 32];
	end
endmodule
`default_nettype wire

[design/nau_ctrl.sv]
// Controller: decodes one command beat and sequences row sweeps.
// Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nau_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [2:0]    op,
	input  wire logic [5:0]    from_square,
	input  wire logic [5:0]    to_square,
	input  wire logic          mover_color,
	input  wire logic [2:0]    moved_piece,
	input  wire logic          promotes,
	input  wire logic [2:0]    promo_piece,
	input  wire logic [2:0]    castle_kind,
	input  wire logic [1:0]    capture_kind,
	input  wire logic [2:0]    captured_piece,
	input  wire logic          sweep_done,
	output logic               busy,
	output nau_pkg::cmd_t      cmd,
	output logic               wr_weight,
	output logic               wr_bias,
	output logic               rd_acc,
	output logic               strobe,
	output logic               is_read
);
	typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_READ, S_DONE} state_t;
	state_t state_q;
	nau_pkg::slot_t slots_q [4];
	logic [2:0] step_q; // bit2 = perspective, [1:0] slot
	logic strobe_q, isrd_q;

	logic acc_in;
	assign acc_in = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign wr_weight = acc_in && op == nau_pkg::OP_WR_WEIGHT;
	assign wr_bias   = acc_in && op == nau_pkg::OP_WR_BIAS;
	assign rd_acc    = acc_in && op == nau_pkg::OP_READ;
	assign strobe  = strobe_q;
	assign is_read = isrd_q;

	// Build the four feature slots of a move
	nau_pkg::slot_t s0, s1, s2, s3;
	logic [5:0] epsq;
	always_comb begin
		epsq = mover_color ? to_square + 6'd8 : to_square - 6'd8;
		s0 = '{1'b1, nau_pkg::feature_of(to_square, mover_color,
			promotes ? promo_piece : moved_piece)};
		s1 = '{1'b0, 11'd0};
		s2 = '{1'b1, nau_pkg::feature_of(from_square, mover_color, moved_piece)};
		s3 = '{1'b0, 11'd0};
		priority case (castle_kind)
			nau_pkg::CastleWq: begin
				s3 = '{1'b1, nau_pkg::feature_of(6'd0, 1'b0, nau_pkg::PieceRook)};
				s1 = '{1'b1, nau_pkg::feature_of(6'd3, 1'b0, nau_pkg::PieceRook)};
			end
			nau_pkg::CastleWk: begin
				s3 = '{1'b1, nau_pkg::feature_of(6'd7, 1'b0, nau_pkg::PieceRook)};
				s1 = '{1'b1, nau_pkg::feature_of(6'd5, 1'b0, nau_pkg::PieceRook)};
			end
			nau_pkg::CastleBq: begin
				s3 = '{1'b1, nau_pkg::feature_of(6'd56, 1'b1, nau_pkg::PieceRook)};
				s1 = '{1'b1, nau_pkg::feature_of(6'd59, 1'b1, nau_pkg::PieceRook)};
			end
			nau_pkg::CastleBk: begin
				s3 = '{1'b1, nau_pkg::feature_of(6'd63, 1'b1, nau_pkg::PieceRook)};
				s1 = '{1'b1, nau_pkg::feature_of(6'd61, 1'b1, nau_pkg::PieceRook)};
			end
			default: ;
		endcase
		if (capture_kind == nau_pkg::CapNormal)
			s3 = '{1'b1, nau_pkg::feature_of(to_square, !mover_color, captured_piece)};
		else if (capture_kind == nau_pkg::CapEp)
			s3 = '{1'b1, nau_pkg::feature_of(epsq, !mover_color, nau_pkg::PiecePawn)};
	end

	// Current slot feature for this perspective
	nau_pkg::slot_t cur;
	logic [10:0] cfeat;
	logic cok;
	always_comb begin
		cur   = slots_q[step_q[1:0]];
		cfeat = cur.feat ^ {10'd0, step_q[2]};
		cok   = cur.vld && (cfeat < 11'(nau_pkg::NumFeatures));
		cmd.bias  = (step_q[1:0] == 2'd3) && !slots_q[0].vld && slots_q[3].vld
			&& slots_q[3].feat == 11'h7FF;
		cmd.run   = (state_q == S_ISSUE) && (cok || cmd.bias);
		cmd.persp = step_q[2];
		cmd.sub   = step_q[1];
		cmd.feat  = cfeat[nau_pkg::FeatW-1:0];
	end

	// Hold state and sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			strobe_q <= 1'b0;
			isrd_q   <= 1'b0;
			for (int i = 0; i < 4; i++) slots_q[i] <= '0;
		end else begin
			strobe_q <= 1'b0;
			isrd_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						step_q <= '0;
						if (op == nau_pkg::OP_MOVE) begin
							slots_q[0] <= s0; slots_q[1] <= s1;
							slots_q[2] <= s2; slots_q[3] <= s3;
							state_q <= S_ISSUE;
						end else if (op == nau_pkg::OP_ADD_PIECE) begin
							slots_q[0] <= '{1'b1, nau_pkg::feature_of(from_square,
								mover_color, moved_piece)};
							slots_q[1] <= '0; slots_q[2] <= '0; slots_q[3] <= '0;
							state_q <= S_ISSUE;
						end else if (op == nau_pkg::OP_RST_ACC) begin
							// bias marker: slot 3 flagged with all-ones feature
							slots_q[0] <= '0; slots_q[1] <= '0; slots_q[2] <= '0;
							slots_q[3] <= '{1'b1, 11'h7FF};
							step_q <= 3'd3;
							state_q <= S_ISSUE;
						end else if (op == nau_pkg::OP_READ) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ISSUE: begin
					if (cmd.bias || cok) state_q <= S_WAIT;
					else if (step_q == 3'd7) state_q <= S_DONE;
					else step_q <= step_q + 3'd1;
				end
				S_WAIT: begin
					if (sweep_done) begin
						if (step_q == 3'd7) state_q <= S_DONE;
						else begin
							step_q  <= step_q + 3'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_READ: begin
					strobe_q <= 1'b1;
					isrd_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_DONE: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/nnue_accumulator_update.sv]
// Top level of the accumulator update block: controller plus datapath.
// Depends on nau_pkg, nau_ctrl, nau_datapath.
//
// Usage: drive op and its fields with start; a beat is taken when start is high
// and busy is low. Each accepted beat yields one result beat, marked by strobe
// for one cycle, on read_value and is_read; the receiver cannot stall it.
// Writes, reads and unknown ops run no sweep. Add piece and move step through eight
// slots (four features by two perspectives); a slot with a row runs a sweep over
// HIDDEN_SIZE/LANES_PER_CYCLE row groups, an empty slot runs none. Reset accumulators
// starts at the last slot of the first perspective and loads the bias row there and
// in the last slot of the second. The result strobe follows the last slot. The row
// sweep engine handles one row group of LANES_PER_CYCLE lanes per cycle.
// One item at a time: busy stays high until its result strobe.
// Reset clears control and the accumulator valid bits, so all lanes read zero.
// Weight and bias words hold no value until written.
`timescale 1ns / 1ps
`default_nettype none
module nnue_accumulator_update #(
	parameter int HIDDEN_SIZE     = nau_pkg::HiddenSizeDefault,
	parameter int LANES_PER_CYCLE = nau_pkg::LanesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  op,
	input  wire logic [17:0] index,
	input  wire logic signed [15:0] value,
	input  wire logic [5:0]  from_square,
	input  wire logic [5:0]  to_square,
	input  wire logic        mover_color,
	input  wire logic [2:0]  moved_piece,
	input  wire logic        promotes,
	input  wire logic [2:0]  promo_piece,
	input  wire logic [2:0]  castle_kind,
	input  wire logic [1:0]  capture_kind,
	input  wire logic [2:0]  captured_piece,
	output logic             strobe,
	output logic signed [31:0] read_value,
	output logic             is_read
);
	nau_pkg::cmd_t cmd;
	logic wr_weight, wr_bias, rd_acc, sweep_done, isrd;
	logic signed [31:0] rv;

	nau_ctrl u_ctrl (
		.clk, .arst_n, .start, .op, .from_square, .to_square, .mover_color,
		.moved_piece, .promotes, .promo_piece, .castle_kind, .capture_kind,
		.captured_piece, .sweep_done, .busy, .cmd, .wr_weight, .wr_bias, .rd_acc,
		.strobe, .is_read(isrd)
	);

	nau_datapath #(.HIDDEN_SIZE(HIDDEN_SIZE), .LANES_PER_CYCLE(LANES_PER_CYCLE)) u_dp (
		.clk, .arst_n, .cmd, .wr_weight, .wr_bias, .rd_acc, .index, .value,
		.done(sweep_done), .read_value(rv)
	);

	assign is_read    = isrd;
	assign read_value = isrd ? rv : 32'sd0;
endmodule
`default_nettype wire

[design/nau_checker.sv]
// Port-level checker for the accumulator update block, bound to the top level.
// Depends on nnue_accumulator_update ports only.
`timescale 1ns / 1ps
`default_nettype none
module nau_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        strobe,
	input wire logic        is_read,
	input wire logic [31:0] read_value
);
	// Accepted beat makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	// A result beat is always the end of a busy period
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy && $past(busy)) else $error("stray strobe");
	// Non-read results carry zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_read |-> read_value == 32'd0) else $error("nonzero value");
	// is_read only with a strobe
	a_isrd: assert property (@(posedge clk) disable iff (!arst_n)
		is_read |-> strobe) else $error("is_read without strobe");
endmodule

bind nnue_accumulator_update nau_checker u_chk (
	.clk, .arst_n, .start, .busy, .strobe, .is_read, .read_value
);
`default_nettype wire

[test/nau_acc_checker.sv]
// Checker for the accumulator update block: watches the command and result
// beats, predicts every result and compares it. Depends on nau_pkg.
`timescale 1ns / 1ps
module nau_acc_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [2:0]         op,
	input  wire logic [17:0]        index,
	input  wire logic signed [15:0] value,
	input  wire logic [5:0]         from_square,
	input  wire logic [5:0]         to_square,
	input  wire logic               mover_color,
	input  wire logic [2:0]         moved_piece,
	input  wire logic               promotes,
	input  wire logic [2:0]         promo_piece,
	input  wire logic [2:0]         castle_kind,
	input  wire logic [1:0]         capture_kind,
	input  wire logic [2:0]         captured_piece,
	input  wire logic               strobe,
	input  wire logic signed [31:0] read_value,
	input  wire logic               is_read,
	output int                      errors,
	output int                      pending
);
	import nau_pkg::*;

	localparam int Hidden   = 256;
	localparam int RowWords = NumFeatures * Hidden;

	typedef struct {
		logic signed [31:0] lane_value;
		logic               answers_read;
	} lane_result_t;

	logic signed [15:0] weights [0:RowWords-1];
	logic signed [15:0] biases [0:Hidden-1];
	logic signed [31:0] acc [0:2*Hidden-1];
	lane_result_t       awaited [$];

	initial begin
		errors = 0;
		for (int i = 0; i < 2 * Hidden; i++) acc[i] = 0;
	end

	assign pending = awaited.size();

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 20) $display("%0t ns: mismatch, %s", $time, what);
	endtask

	function automatic logic [10:0] feature_at(input logic [5:0] sq, input logic colour,
			input logic [2:0] piece);
		return {piece, (colour ? (sq ^ 6'd56) : sq), colour};
	endfunction

	// Add or subtract one weight row into one perspective, saturating each lane
	task automatic sweep_row(input logic persp, input logic [10:0] feat, input logic used,
			input logic sub);
		int    row;
		longint sum;
		longint w;
		if (!used) return;
		row = int'(feat ^ {10'd0, persp});
		if (row >= NumFeatures) return;
		for (int lane = 0; lane < Hidden; lane++) begin
			w = longint'(weights[row * Hidden + lane]);
			sum = longint'(acc[int'(persp) * Hidden + lane]) + (sub ? -w : w);
			if (sum > 64'sd2147483647) sum = 64'sd2147483647;
			if (sum < -64'sd2147483648) sum = -64'sd2147483648;
			acc[int'(persp) * Hidden + lane] = sum[31:0];
		end
	endtask

	// Work out the state change and the result of one accepted command beat
	task automatic predict_beat();
		lane_result_t res;
		logic [10:0]  add0, add1, rem0, rem1;
		logic         add1_used, rem1_used;
		logic [5:0]   ep_sq;
		res.lane_value = 0;
		res.answers_read = 1'b0;
		case (op)
			OP_WR_WEIGHT: if (index < RowWords) weights[index] = value;
			OP_WR_BIAS:   if (index < Hidden) biases[index] = value;
			OP_RST_ACC: begin
				for (int i = 0; i < 2 * Hidden; i++) acc[i] = 32'(biases[i % Hidden]);
			end
			OP_ADD_PIECE: begin
				add0 = feature_at(from_square, mover_color, moved_piece);
				sweep_row(1'b0, add0, 1'b1, 1'b0);
				sweep_row(1'b1, add0, 1'b1, 1'b0);
			end
			OP_MOVE: begin
				rem0 = feature_at(from_square, mover_color, moved_piece);
				add0 = feature_at(to_square, mover_color, promotes ? promo_piece : moved_piece);
				add1_used = 1'b1;
				rem1_used = 1'b1;
				add1 = '0;
				rem1 = '0;
				case (castle_kind)
					CastleWq: begin
						rem1 = feature_at(6'd0, 1'b0, PieceRook);
						add1 = feature_at(6'd3, 1'b0, PieceRook);
					end
					CastleWk: begin
						rem1 = feature_at(6'd7, 1'b0, PieceRook);
						add1 = feature_at(6'd5, 1'b0, PieceRook);
					end
					CastleBq: begin
						rem1 = feature_at(6'd56, 1'b1, PieceRook);
						add1 = feature_at(6'd59, 1'b1, PieceRook);
					end
					CastleBk: begin
						rem1 = feature_at(6'd63, 1'b1, PieceRook);
						add1 = feature_at(6'd61, 1'b1, PieceRook);
					end
					default: begin
						add1_used = 1'b0;
						rem1_used = 1'b0;
					end
				endcase
				// a capture takes the second removal slot over from the rook
				if (capture_kind == CapNormal) begin
					rem1 = feature_at(to_square, ~mover_color, captured_piece);
					rem1_used = 1'b1;
				end else if (capture_kind == CapEp) begin
					ep_sq = mover_color ? (to_square + 6'd8) : (to_square - 6'd8);
					rem1 = feature_at(ep_sq, ~mover_color, PiecePawn);
					rem1_used = 1'b1;
				end
				for (int p = 0; p < 2; p++) begin
					sweep_row(p[0], add0, 1'b1, 1'b0);
					sweep_row(p[0], add1, add1_used, 1'b0);
					sweep_row(p[0], rem0, 1'b1, 1'b1);
					sweep_row(p[0], rem1, rem1_used, 1'b1);
				end
			end
			OP_READ: begin
				res.answers_read = 1'b1;
				if (index < 2 * Hidden) res.lane_value = acc[index];
			end
			default: ;
		endcase
		awaited.push_back(res);
	endtask

	// Compare each result beat with the oldest prediction, then take new commands
	always @(posedge clk) begin
		lane_result_t exp_res;
		if (arst_n) begin
			if (strobe) begin
				if (awaited.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					exp_res = awaited.pop_front();
					if (is_read !== exp_res.answers_read)
						report_mismatch($sformatf("is_read %b, want %b", is_read,
								exp_res.answers_read));
					if (read_value !== exp_res.lane_value)
						report_mismatch($sformatf("read_value %0d, want %0d", read_value,
								exp_res.lane_value));
				end
			end
			if (start && !busy) predict_beat();
		end
	end
endmodule

[test/nnue_accumulator_update_tb.sv]
// Testbench top for the accumulator update block: reset, command stimulus and verdict.
// Depends on nau_pkg, nnue_accumulator_update and nau_acc_checker.
`timescale 1ns / 1ps
module nnue_accumulator_update_tb;
	import nau_pkg::*;

	localparam int  Hidden      = 256;
	localparam int  RandomBeats = 400;
	localparam int  CycleLimit  = 3000000;
	localparam logic [2:0] OpSpareLo   = 3'd6;
	localparam logic [2:0] OpSpareHi   = 3'd7;
	localparam logic [2:0] CastleNone  = 3'd0;
	localparam logic [2:0] CastleBad   = 3'd5;
	localparam logic [1:0] CapNone     = 2'd0;
	localparam logic [1:0] CapBad      = 2'd3;
	localparam logic [2:0] PieceKing   = 3'd5;
	localparam logic [2:0] PieceNoRow  = 3'd7;
	localparam logic [5:0] KeySquares [0:7] = '{6'd0, 6'd3, 6'd5, 6'd7,
			6'd56, 6'd59, 6'd61, 6'd63};
	// Lanes written in every key row and in the bias row; only these are read back
	localparam int  TestLanes [0:3] = '{0, 7, 8, Hidden - 1};

	typedef struct {
		logic [2:0]         op;
		logic [17:0]        index;
		logic signed [15:0] value;
		logic [5:0]         from_sq;
		logic [5:0]         to_sq;
		logic               colour;
		logic [2:0]         piece;
		logic               promo;
		logic [2:0]         promo_piece;
		logic [2:0]         castle;
		logic [1:0]         capture;
		logic [2:0]         captured;
	} cmd_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         op = '0;
	logic [17:0]        index = '0;
	logic signed [15:0] value = '0;
	logic [5:0]         from_square = '0;
	logic [5:0]         to_square = '0;
	logic               mover_color = 1'b0;
	logic [2:0]         moved_piece = '0;
	logic               promotes = 1'b0;
	logic [2:0]         promo_piece = '0;
	logic [2:0]         castle_kind = '0;
	logic [1:0]         capture_kind = '0;
	logic [2:0]         captured_piece = '0;
	logic               strobe;
	logic signed [31:0] read_value;
	logic               is_read;
	int                 errors;
	int                 pending;
	int                 cycles = 0;
	logic [63:0]        key_mask;

	nnue_accumulator_update i_dut (
		.clk, .arst_n, .start, .busy, .op, .index, .value, .from_square, .to_square,
		.mover_color, .moved_piece, .promotes, .promo_piece, .castle_kind,
		.capture_kind, .captured_piece, .strobe, .read_value, .is_read
	);

	nau_acc_checker i_checker (
		.clk, .arst_n, .start, .busy, .op, .index, .value, .from_square, .to_square,
		.mover_color, .moved_piece, .promotes, .promo_piece, .castle_kind,
		.capture_kind, .captured_piece, .strobe, .read_value, .is_read, .errors, .pending
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The loading phase writes only rows on the key squares, so every sweep must stay on them
	function automatic logic row_written(input logic [5:0] sq, input logic colour,
			input logic [2:0] piece);
		logic [5:0] s;
		s = colour ? (sq ^ 6'd56) : sq;
		return (piece > PieceKing) || key_mask[s];
	endfunction

	function automatic logic move_safe(input cmd_beat_t b);
		logic [5:0] ep_sq;
		logic       ok;
		ep_sq = b.colour ? (b.to_sq + 6'd8) : (b.to_sq - 6'd8);
		ok = row_written(b.from_sq, b.colour, b.piece)
				&& row_written(b.to_sq, b.colour, b.promo ? b.promo_piece : b.piece);
		if (b.capture == CapNormal) ok = ok && row_written(b.to_sq, ~b.colour, b.captured);
		if (b.capture == CapEp) ok = ok && row_written(ep_sq, ~b.colour, PiecePawn);
		return ok;
	endfunction

	function automatic logic [5:0] pick_square();
		return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
				: KeySquares[$urandom_range(0, 7)];
	endfunction

	function automatic logic [2:0] pick_piece();
		return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
	endfunction

	function automatic cmd_beat_t noise_beat(input logic [2:0] code);
		cmd_beat_t b;
		b.op = code;
		b.index = 18'($urandom());
		b.value = 16'($urandom());
		b.from_sq = 6'($urandom());
		b.to_sq = 6'($urandom());
		b.colour = 1'($urandom());
		b.piece = 3'($urandom());
		b.promo = 1'($urandom());
		b.promo_piece = 3'($urandom());
		b.castle = 3'($urandom());
		b.capture = 2'($urandom());
		b.captured = 3'($urandom());
		return b;
	endfunction

	// Build a move or an added piece on written rows; a negative kind draws it at random
	function automatic cmd_beat_t piece_beat(input logic [2:0] code, input int castle,
			input int capture, input int promo);
		cmd_beat_t b;
		for (int tries = 0; tries < 200; tries++) begin
			b = noise_beat(code);
			b.from_sq = pick_square();
			b.to_sq = pick_square();
			b.piece = pick_piece();
			b.promo_piece = pick_piece();
			b.captured = pick_piece();
			if (castle >= 0) b.castle = 3'(castle);
			if (capture >= 0) b.capture = 2'(capture);
			if (promo >= 0) b.promo = 1'(promo);
			if (code == OP_ADD_PIECE) begin
				if (row_written(b.from_sq, b.colour, b.piece)) return b;
			end else if (move_safe(b)) begin
				return b;
			end
		end
		// fall back to pieces that have no row at all
		b.piece = PieceNoRow;
		b.promo_piece = PieceNoRow;
		b.capture = CapNone;
		return b;
	endfunction

	function automatic cmd_beat_t simple_beat(input logic [2:0] code, input int idx,
			input int val);
		cmd_beat_t b;
		b = noise_beat(code);
		b.index = 18'(idx);
		b.value = 16'(val);
		return b;
	endfunction

	// Optionally hold off start, then present the beat until it is taken
	task automatic issue(input cmd_beat_t b);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= b.op;
		index <= b.index;
		value <= b.value;
		from_square <= b.from_sq;
		to_square <= b.to_sq;
		mover_color <= b.colour;
		moved_piece <= b.piece;
		promotes <= b.promo;
		promo_piece <= b.promo_piece;
		castle_kind <= b.castle;
		capture_kind <= b.capture;
		captured_piece <= b.captured;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	initial begin
		int pick;
		int feat;
		int wval;
		key_mask = '0;
		foreach (KeySquares[k]) key_mask[KeySquares[k]] = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads straight after reset, out-of-range accesses and spare op codes
		issue(simple_beat(OP_READ, 0, 0));
		issue(simple_beat(OP_READ, 511, 0));
		issue(simple_beat(OP_READ, 512, 0));
		issue(simple_beat(OP_READ, 262143, 0));
		issue(noise_beat(OpSpareLo));
		issue(noise_beat(OpSpareHi));
		issue(simple_beat(OP_WR_WEIGHT, NumFeatures * Hidden, 1234));
		issue(simple_beat(OP_WR_WEIGHT, 262143, -1));
		issue(simple_beat(OP_WR_BIAS, Hidden, 77));
		issue(simple_beat(OP_WR_BIAS, 511, -77));

		// Load the test lanes of the bias row and of every row on the key squares
		foreach (TestLanes[t]) begin
			wval = (TestLanes[t] == 0) ? -32768 : (TestLanes[t] == Hidden - 1) ? 32767
					: int'($urandom_range(0, 65535));
			issue(simple_beat(OP_WR_BIAS, TestLanes[t], wval));
		end
		for (int piece = 0; piece <= int'(PieceKing); piece++)
			foreach (KeySquares[k])
				for (int colour = 0; colour < 2; colour++) begin
					feat = int'({3'(piece), KeySquares[k], 1'(colour)});
					foreach (TestLanes[t]) begin
						wval = (TestLanes[t] == 0) ? -32768
								: (TestLanes[t] == Hidden - 1) ? 32767
								: int'($urandom_range(0, 65535));
						issue(simple_beat(OP_WR_WEIGHT, feat * Hidden + TestLanes[t], wval));
					end
				end

		// Every move shape: each castle, each capture kind, promotion
		issue(noise_beat(OP_RST_ACC));
		issue(piece_beat(OP_ADD_PIECE, -1, -1, -1));
		for (int c = 0; c <= 5; c++) issue(piece_beat(OP_MOVE, c, int'(CapNone), 0));
		issue(piece_beat(OP_MOVE, int'(CastleBad) + 2, int'(CapNone), 0));
		issue(piece_beat(OP_MOVE, int'(CastleWk), int'(CapNormal), 0));
		issue(piece_beat(OP_MOVE, int'(CastleNone), int'(CapEp), 0));
		issue(piece_beat(OP_MOVE, int'(CastleNone), int'(CapBad), 1));
		issue(simple_beat(OP_READ, 0, 0));
		issue(simple_beat(OP_READ, Hidden - 1, 0));
		issue(simple_beat(OP_READ, Hidden, 0));
		issue(simple_beat(OP_READ, 2 * Hidden - 1, 0));

		// Random traffic, mostly moves and reads of the test lanes
		for (int n = 0; n < RandomBeats; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) issue(simple_beat(OP_WR_WEIGHT, $urandom_range(0, 262143),
					$urandom_range(0, 65535)));
			else if (pick < 10) issue(simple_beat(OP_WR_BIAS, $urandom_range(0, 300),
					$urandom_range(0, 65535)));
			else if (pick < 14) issue(noise_beat(OP_RST_ACC));
			else if (pick < 30) issue(piece_beat(OP_ADD_PIECE, -1, -1, -1));
			else if (pick < 62) issue(piece_beat(OP_MOVE, -1, -1, -1));
			else if (pick < 92) issue(simple_beat(OP_READ,
					int'($urandom_range(0, 1)) * Hidden + TestLanes[$urandom_range(0, 3)], 0));
			else if (pick < 95) issue(simple_beat(OP_READ,
					$urandom_range(2 * Hidden, 262143), 0));
			else issue(noise_beat(($urandom_range(0, 1) == 0) ? OpSpareLo : OpSpareHi));
		end
		start <= 1'b0;

		// Drain outstanding results, then keep the clock running to catch stray beats
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

[nnue_accumulator_update.f]
design/nau_pkg.sv
design/nau_datapath.sv
design/nau_ctrl.sv
design/nnue_accumulator_update.sv
design/nau_checker.sv
test/nau_acc_checker.sv
test/nnue_accumulator_update_tb.sv
